/* src/bgsl_pkg.sv */
// Shared types and constants for the gain-schedule lookup.
package bgsl_pkg;

	typedef enum logic [1:0] {
		OP_QUERY      = 2'd0,
		OP_LOAD_MACH  = 2'd1,
		OP_LOAD_ALT   = 2'd2,
		OP_LOAD_TABLE = 2'd3
	} op_t;

	localparam int NUM_TABLES = 4;
	localparam int NUM_LANES  = 8;
	localparam int BM_W       = 33;
	localparam int ITER_W     = 6;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] table_select;
		logic [3:0] row_index;
		logic [3:0] col_index;
		word_t      load_value;
		word_t      mach_value;
		word_t      alt_value;
		logic       in_range;
	} cmd_t;

endpackage

/* src/bgsl_in_if.sv */
// Input channel: query and load items.
interface bgsl_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [1:0]         table_select;
	logic [3:0]         row_index;
	logic [3:0]         col_index;
	logic signed [31:0] load_value;
	logic signed [31:0] mach_value;
	logic signed [31:0] alt_value;

	modport source (output valid, op, table_select, row_index, col_index, load_value,
		mach_value, alt_value, input ready);
	modport sink (input valid, op, table_select, row_index, col_index, load_value,
		mach_value, alt_value, output ready);
endinterface

/* src/bgsl_out_if.sv */
// Output channel: interpolated gains.
interface bgsl_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] alpha_gain;
	logic signed [31:0] pitch_rate_gain;
	logic signed [31:0] roll_rate_gain;
	logic signed [31:0] integral_gain;
	logic               degenerate_cell;

	modport source (output valid, alpha_gain, pitch_rate_gain, roll_rate_gain,
		integral_gain, degenerate_cell, input ready);
	modport sink (input valid, alpha_gain, pitch_rate_gain, roll_rate_gain,
		integral_gain, degenerate_cell, output ready);
endinterface

/* src/bgsl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bgsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/bgsl_front.sv */
// Front end: accepts items, checks load indexes, two-entry command queue.
module bgsl_front #(
	parameter int MACH_POINTS = 16,
	parameter int ALT_POINTS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	bgsl_in_if.sink         cmd,
	output logic            cmd_valid,
	output bgsl_pkg::cmd_t  cmd_data,
	input  logic            cmd_pop
);
	bgsl_pkg::cmd_t entry_q [2];
	bgsl_pkg::cmd_t item;
	logic           wptr_q, rptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           col_ok, row_ok;

	assign cmd.ready = (count_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd_data  = entry_q[rptr_q];

	assign col_ok = ({1'b0, cmd.col_index} < 5'(MACH_POINTS));
	assign row_ok = ({1'b0, cmd.row_index} < 5'(ALT_POINTS));

	always_comb begin
		item.op           = bgsl_pkg::op_t'(cmd.op);
		item.table_select = cmd.table_select;
		item.row_index    = cmd.row_index;
		item.col_index    = cmd.col_index;
		item.load_value   = cmd.load_value;
		item.mach_value   = cmd.mach_value;
		item.alt_value    = cmd.alt_value;
		unique case (item.op)
			bgsl_pkg::OP_QUERY:      item.in_range = 1'b1;
			bgsl_pkg::OP_LOAD_MACH:  item.in_range = col_ok;
			bgsl_pkg::OP_LOAD_ALT:   item.in_range = row_ok;
			bgsl_pkg::OP_LOAD_TABLE: item.in_range = col_ok && row_ok;
			default:                 item.in_range = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

/* src/bgsl_muldiv.sv */
// Bit-serial lane: q = floor(am * bm / dm) for am <= dm, one bit of bm per step.
module bgsl_muldiv (
	input  logic        clk,
	input  logic        load,
	input  logic        step,
	input  logic [31:0] am,
	input  logic [31:0] dm,
	input  logic [32:0] bm,
	output logic [32:0] q
);
	logic [31:0] am_q, dm_q, r_q;
	logic [32:0] b_q, q_q;
	logic [33:0] r2;
	logic [34:0] t1, t2;

	// remainder stays below dm; r2 < 3*dm so at most two subtractions
	assign r2 = {1'b0, r_q, 1'b0} + (b_q[32] ? {2'b00, am_q} : 34'd0);
	assign t1 = {1'b0, r2} - {3'b000, dm_q};
	assign t2 = {1'b0, r2} - {2'b00, dm_q, 1'b0};
	assign q  = q_q;

	always_ff @(posedge clk) begin
		if (load) begin
			am_q <= am;
			dm_q <= dm;
			b_q  <= bm;
			r_q  <= 32'd0;
			q_q  <= 33'd0;
		end else if (step) begin
			b_q <= {b_q[31:0], 1'b0};
			if (!t2[34]) begin
				r_q <= t2[31:0];
				q_q <= {q_q[31:0], 1'b0} + 33'd2;
			end else if (!t1[34]) begin
				r_q <= t1[31:0];
				q_q <= {q_q[31:0], 1'b0} + 33'd1;
			end else begin
				r_q <= r2[31:0];
				q_q <= {q_q[31:0], 1'b0};
			end
		end
	end
endmodule

/* src/bgsl_back.sv */
// Back end: table storage, breakpoint scan, corner fetch, two interpolation passes.
module bgsl_back #(
	parameter int MACH_POINTS = 16,
	parameter int ALT_POINTS  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  bgsl_pkg::cmd_t cmd_data,
	output logic           cmd_pop,
	bgsl_out_if.source     res
);
	localparam int MAW = $clog2(MACH_POINTS);
	localparam int AAW = $clog2(ALT_POINTS);
	localparam int KW  = (MAW > AAW) ? MAW : AAW;
	localparam int TAW = MAW + AAW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_CORNER, ST_MACH, ST_MID, ST_ALTLD, ST_ALT, ST_FIN, ST_OUT
	} state_t;

	state_t st_q;
	logic [KW-1:0]                   k_q;
	logic                            mdone_q, adone_q;
	logic [2:0]                      cc_q;
	logic [bgsl_pkg::ITER_W-1:0]     it_q;
	logic                            out_valid_q;

	bgsl_pkg::word_t mach_v_q, alt_v_q, mprev_q, aprev_q;
	bgsl_pkg::word_t x1_q, x2_q, y1_q, y2_q;
	logic            mfirst_q, afirst_q, degen_q;
	logic [MAW-1:0]  mb_q;
	logic [AAW-1:0]  ab_q;
	bgsl_pkg::word_t z_q [bgsl_pkg::NUM_TABLES][4];
	bgsl_pkg::word_t lo_q [bgsl_pkg::NUM_TABLES];
	bgsl_pkg::word_t hi_q [bgsl_pkg::NUM_TABLES];
	bgsl_pkg::word_t gain_q [bgsl_pkg::NUM_TABLES];
	logic [bgsl_pkg::NUM_LANES-1:0] neg_q;
	bgsl_pkg::word_t res_gain_q [bgsl_pkg::NUM_TABLES];
	logic            res_degen_q;

	// storage ports
	logic            mbp_we, abp_we;
	logic [MAW-1:0]  mbp_ra;
	logic [AAW-1:0]  abp_ra;
	logic [31:0]     mbp_rd, abp_rd;
	logic [bgsl_pkg::NUM_TABLES-1:0] tab_we;
	logic [TAW-1:0]  tab_wa, tab_ra;
	logic [31:0]     tab_rd [bgsl_pkg::NUM_TABLES];
	logic [MAW-1:0]  tcol;
	logic [AAW-1:0]  trow;

	// scan
	logic [KW:0]     kn;
	logic            mgt, agt, m_hit, a_hit, m_fin, a_fin;

	// lanes
	logic            lane_load, lane_step, degen;
	logic [31:0]     am_m, dm_m, am_a, dm_a, am_sel, dm_sel;
	logic [32:0]     lane_bm [bgsl_pkg::NUM_LANES];
	logic [bgsl_pkg::NUM_LANES-1:0] lane_neg;
	logic [32:0]     lane_q [bgsl_pkg::NUM_LANES];

	function automatic logic [63:0] span(bgsl_pkg::word_t lo, bgsl_pkg::word_t hi,
		bgsl_pkg::word_t v);
		logic signed [32:0] d, a;
		logic [32:0]        dmag, amag;
		d = {hi[31], hi} - {lo[31], lo};
		if (v < lo) begin
			a = 33'sd0;
		end else if (v > hi) begin
			a = d;
		end else begin
			a = {v[31], v} - {lo[31], lo};
		end
		dmag = d[32] ? -d : d;
		amag = a[32] ? -a : a;
		return {amag[31:0], dmag[31:0]};
	endfunction

	function automatic logic [33:0] delta(bgsl_pkg::word_t z1, bgsl_pkg::word_t z2);
		logic [32:0] dd;
		dd = {z2[31], z2} - {z1[31], z1};
		return {dd[32], dd[32] ? -dd : dd};
	endfunction

	function automatic bgsl_pkg::word_t apply(bgsl_pkg::word_t z1, logic neg,
		logic [32:0] q);
		logic [33:0] s;
		s = {{2{z1[31]}}, z1} + (neg ? -{1'b0, q} : {1'b0, q});
		return s[31:0];
	endfunction

	assign cmd_pop = (st_q == ST_IDLE) && cmd_valid;

	// loads are written straight from the queue head
	assign mbp_we = cmd_pop && cmd_data.in_range && (cmd_data.op == bgsl_pkg::OP_LOAD_MACH);
	assign abp_we = cmd_pop && cmd_data.in_range && (cmd_data.op == bgsl_pkg::OP_LOAD_ALT);
	assign tab_wa = {cmd_data.row_index[AAW-1:0], cmd_data.col_index[MAW-1:0]};

	always_comb begin
		for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
			tab_we[t] = cmd_pop && cmd_data.in_range
				&& (cmd_data.op == bgsl_pkg::OP_LOAD_TABLE)
				&& (cmd_data.table_select == 2'(t));
		end
	end

	// next scan address, held at the last breakpoint of each axis
	assign kn = {1'b0, k_q} + (KW+1)'(1);
	always_comb begin
		if (st_q != ST_SCAN) begin
			mbp_ra = '0;
			abp_ra = '0;
		end else begin
			mbp_ra = (kn >= (KW+1)'(MACH_POINTS)) ? MAW'(MACH_POINTS - 1) : kn[MAW-1:0];
			abp_ra = (kn >= (KW+1)'(ALT_POINTS)) ? AAW'(ALT_POINTS - 1) : kn[AAW-1:0];
		end
	end

	assign mgt   = $signed(mbp_rd) > mach_v_q;
	assign agt   = $signed(abp_rd) > alt_v_q;
	assign m_hit = (k_q != '0) && (mgt || mfirst_q || (k_q == KW'(MACH_POINTS - 1)));
	assign a_hit = (k_q != '0) && (agt || afirst_q || (k_q == KW'(ALT_POINTS - 1)));
	assign m_fin = mdone_q || m_hit;
	assign a_fin = adone_q || a_hit;

	// corner order: (a-1,b-1), (a-1,b), (a,b-1), (a,b)
	assign trow   = cc_q[1] ? ab_q : ab_q - AAW'(1);
	assign tcol   = cc_q[0] ? mb_q : mb_q - MAW'(1);
	assign tab_ra = {trow, tcol};

	bgsl_ram #(.WIDTH(32), .DEPTH(MACH_POINTS)) u_mach_bp (
		.clk(clk), .we(mbp_we), .waddr(cmd_data.col_index[MAW-1:0]),
		.wdata(cmd_data.load_value), .raddr(mbp_ra), .rdata(mbp_rd)
	);

	bgsl_ram #(.WIDTH(32), .DEPTH(ALT_POINTS)) u_alt_bp (
		.clk(clk), .we(abp_we), .waddr(cmd_data.row_index[AAW-1:0]),
		.wdata(cmd_data.load_value), .raddr(abp_ra), .rdata(abp_rd)
	);

	for (genvar t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin : g_tab
		bgsl_ram #(.WIDTH(32), .DEPTH(1 << TAW)) u_tab (
			.clk(clk), .we(tab_we[t]), .waddr(tab_wa), .wdata(cmd_data.load_value),
			.raddr(tab_ra), .rdata(tab_rd[t])
		);
	end

	assign degen     = (x1_q == x2_q) || (y1_q == y2_q);
	assign lane_load = ((st_q == ST_CORNER) && (cc_q == 3'd5) && !degen) || (st_q == ST_ALTLD);
	assign lane_step = (st_q == ST_MACH) || (st_q == ST_ALT);
	assign {am_m, dm_m} = span(x1_q, x2_q, mach_v_q);
	assign {am_a, dm_a} = span(y1_q, y2_q, alt_v_q);
	assign am_sel = (st_q == ST_ALTLD) ? am_a : am_m;
	assign dm_sel = (st_q == ST_ALTLD) ? dm_a : dm_m;

	always_comb begin
		for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
			if (st_q == ST_ALTLD) begin
				{lane_neg[t], lane_bm[t]} = delta(lo_q[t], hi_q[t]);
				{lane_neg[t+4], lane_bm[t+4]} = delta(lo_q[t], hi_q[t]);
			end else begin
				{lane_neg[t], lane_bm[t]} = delta(z_q[t][0], z_q[t][1]);
				{lane_neg[t+4], lane_bm[t+4]} = delta(z_q[t][2], z_q[t][3]);
			end
		end
	end

	for (genvar l = 0; l < bgsl_pkg::NUM_LANES; l++) begin : g_lane
		bgsl_muldiv u_lane (
			.clk(clk), .load(lane_load), .step(lane_step), .am(am_sel), .dm(dm_sel),
			.bm(lane_bm[l]), .q(lane_q[l])
		);
	end

	assign res.valid           = out_valid_q;
	assign res.alpha_gain      = res_gain_q[0];
	assign res.pitch_rate_gain = res_gain_q[1];
	assign res.roll_rate_gain  = res_gain_q[2];
	assign res.integral_gain   = res_gain_q[3];
	assign res.degenerate_cell = res_degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			k_q         <= '0;
			mdone_q     <= 1'b0;
			adone_q     <= 1'b0;
			cc_q        <= 3'd0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd_data.op == bgsl_pkg::OP_QUERY)) begin
						k_q     <= '0;
						mdone_q <= 1'b0;
						adone_q <= 1'b0;
						st_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					mdone_q <= m_fin;
					adone_q <= a_fin;
					k_q     <= kn[KW-1:0];
					if (m_fin && a_fin) begin
						cc_q <= 3'd0;
						st_q <= ST_CORNER;
					end
				end
				ST_CORNER: begin
					cc_q <= cc_q + 3'd1;
					if (cc_q == 3'd5) begin
						it_q <= '0;
						st_q <= degen ? ST_OUT : ST_MACH;
					end
				end
				ST_MACH: begin
					it_q <= it_q + bgsl_pkg::ITER_W'(1);
					if (it_q == bgsl_pkg::ITER_W'(bgsl_pkg::BM_W - 1)) begin
						st_q <= ST_MID;
					end
				end
				ST_MID: begin
					st_q <= ST_ALTLD;
				end
				ST_ALTLD: begin
					it_q <= '0;
					st_q <= ST_ALT;
				end
				ST_ALT: begin
					it_q <= it_q + bgsl_pkg::ITER_W'(1);
					if (it_q == bgsl_pkg::ITER_W'(bgsl_pkg::BM_W - 1)) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				mach_v_q <= cmd_data.mach_value;
				alt_v_q  <= cmd_data.alt_value;
			end
			ST_SCAN: begin
				if (!mdone_q) begin
					if (k_q == '0) begin
						mfirst_q <= mgt;
					end
					mprev_q <= mbp_rd;
					if (m_hit) begin
						x1_q <= mprev_q;
						x2_q <= mbp_rd;
						mb_q <= k_q[MAW-1:0];
					end
				end
				if (!adone_q) begin
					if (k_q == '0) begin
						afirst_q <= agt;
					end
					aprev_q <= abp_rd;
					if (a_hit) begin
						y1_q <= aprev_q;
						y2_q <= abp_rd;
						ab_q <= k_q[AAW-1:0];
					end
				end
			end
			ST_CORNER: begin
				if (cc_q != 3'd0 && cc_q != 3'd5) begin
					for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
						z_q[t][2'(cc_q - 3'd1)] <= tab_rd[t];
					end
				end
				if (cc_q == 3'd5) begin
					degen_q <= degen;
					neg_q   <= lane_neg;
					for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
						gain_q[t] <= z_q[t][0];
					end
				end
			end
			ST_MID: begin
				for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
					lo_q[t] <= apply(z_q[t][0], neg_q[t], lane_q[t]);
					hi_q[t] <= apply(z_q[t][2], neg_q[t+4], lane_q[t+4]);
				end
			end
			ST_ALTLD: begin
				neg_q <= lane_neg;
			end
			ST_FIN: begin
				for (int t = 0; t < bgsl_pkg::NUM_TABLES; t++) begin
					gain_q[t] <= apply(lo_q[t], neg_q[t], lane_q[t]);
				end
			end
			ST_OUT: begin
				if (!out_valid_q || res.ready) begin
					res_gain_q  <= gain_q;
					res_degen_q <= degen_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

/* src/bilinear_gain_schedule_lookup_unit.sv */
// Gain-schedule lookup: 2-D breakpoint search and bilinear interpolation of four tables.
// Loads are written from the head of the two-entry command queue while the back end is idle.
// A query runs a breakpoint scan over both axes and a corner fetch, then two 33-step bit-serial
// multiply-divide passes; a degenerate cell skips the passes.
// One query in flight; the queue and output register keep the two sides decoupled.
// arst_n clears control only; breakpoint and table storage hold garbage until loaded.
module bilinear_gain_schedule_lookup_unit #(
	parameter int MACH_POINTS = 16,
	parameter int ALT_POINTS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bgsl_in_if.sink     cmd,
	bgsl_out_if.source  res
);
	logic           cmd_valid;
	logic           cmd_pop;
	bgsl_pkg::cmd_t cmd_data;

	bgsl_front #(.MACH_POINTS(MACH_POINTS), .ALT_POINTS(ALT_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cmd_valid(cmd_valid), .cmd_data(cmd_data), .cmd_pop(cmd_pop)
	);

	bgsl_back #(.MACH_POINTS(MACH_POINTS), .ALT_POINTS(ALT_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_data(cmd_data), .cmd_pop(cmd_pop), .res(res)
	);
endmodule
